// ----- src/central_difference_derivative_top_assert.svh -----
// Assertion macros for the derivative block; clocked on clock, disabled in reset.
// Taken in by the files that assert; depends on nothing else.
`ifndef CENTRAL_DIFFERENCE_DERIVATIVE_TOP_ASSERT_SVH
`define CENTRAL_DIFFERENCE_DERIVATIVE_TOP_ASSERT_SVH

// same-cycle implication
`define CDD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CDD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/cdd_pkg.sv -----
// Shared types and defaults for the central-difference derivative block.
// Used by cdd_iter_unit and the top level; depends on nothing.
`timescale 1ns / 1ps

package cdd_pkg;

   localparam int CDD_WORD_BITS = 32;
   localparam int CDD_FRAC_BITS = 16;

   // operations of the shared add/subtract unit
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD,
      OP_MUL,
      OP_DIV,
      OP_ABS
   } cdd_op_type;

   typedef struct packed {
      cdd_op_type op;
      logic       sub;
   } cdd_ctl_type;

endpackage

// ----- src/cdd_iter_unit.sv -----
// Shared iterative datapath: one wide adder/subtractor driving shift-add
// multiply steps, restoring divide steps and an absolute-value step.
// Depends on cdd_pkg.
`timescale 1ns / 1ps

module cdd_iter_unit
   import cdd_pkg::*;
#(
   parameter int AW  = 129,
   parameter int MW  = 33,
   parameter int SHL = 33
) (
   input  logic          clock,
   input  cdd_ctl_type   ctl,
   input  logic [AW-1:0] r_ld,
   input  logic [AW-1:0] y_ld,
   input  logic [MW-1:0] m_ld,
   output logic [AW-1:0] r_out,
   output logic [MW-1:0] m_out,
   output logic          r_neg
);

   logic [AW-1:0] r_ff, r_in;
   logic [AW-1:0] y_ff, y_in;
   logic [MW-1:0] m_ff, m_in;
   logic [AW-1:0] op_a;
   logic [AW-1:0] op_b;
   logic          op_sub;
   logic [AW:0]   sum;
   logic          ge;

   always_comb begin
      case (ctl.op)
         OP_MUL: begin
            op_a   = r_ff;
            op_b   = y_ff;
            op_sub = ctl.sub;
         end
         OP_DIV: begin
            op_a   = r_ff;
            op_b   = y_ff;
            op_sub = 1'b1;
         end
         OP_ABS: begin
            op_a   = '0;
            op_b   = r_ff;
            op_sub = 1'b1;
         end
         default: begin
            op_a   = r_ff;
            op_b   = y_ff;
            op_sub = 1'b0;
         end
      endcase
   end

   assign sum = {1'b0, op_a} + ({1'b0, op_b} ^ {(AW+1){op_sub}}) + (AW+1)'(op_sub);
   // top bit of the extended difference is the borrow
   assign ge  = ~sum[AW];

   always_comb begin
      r_in = r_ff;
      y_in = y_ff;
      m_in = m_ff;
      case (ctl.op)
         OP_LOAD: begin
            r_in = r_ld;
            y_in = y_ld;
            m_in = m_ld;
         end
         OP_MUL: begin
            if (m_ff[0]) begin
               r_in = sum[AW-1:0];
            end
            y_in = y_ff << 1;
            m_in = m_ff >> 1;
         end
         OP_DIV: begin
            if (ge) begin
               r_in = sum[AW-1:0];
            end
            y_in = y_ff >> 1;
            m_in = {m_ff[MW-2:0], ge};
         end
         OP_ABS: begin
            r_in = (r_ff[AW-1] ? sum[AW-1:0] : r_ff) << SHL;
            y_in = y_ld;
            m_in = m_ld;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      y_ff <= y_in;
      m_ff <= m_in;
   end

   assign r_out = r_ff;
   assign m_out = m_ff;
   assign r_neg = r_ff[AW-1];

endmodule

// ----- src/central_difference_derivative_top.sv -----
// Top level of the central-difference derivative block: sample window,
// sequencer and result register around the shared unit cdd_iter_unit.
// Depends on cdd_pkg and central_difference_derivative_top_assert.svh.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | sample_time, sample_position,
//           |           |                    |   first_of_series
//   rsp_    | out       | rsp_valid/rsp_stall | mid_time, mid_position, velocity,
//           |           |                    |   acceleration, span_error, saturated
//
// A sample that restarts or fills the window leaves the block idle and yields nothing.
// A full-window sample with a bad time step goes straight to the result write.
// Otherwise the work is four shift-add products and two restoring divisions,
// one step per cycle through the one shared adder.
// req_stall is high from the transfer until the result enters the output
// register; a held result stalls only the final write. Synchronous reset.
`timescale 1ns / 1ps
`include "central_difference_derivative_top_assert.svh"

module central_difference_derivative_top
   import cdd_pkg::*;
#(
   parameter int WORD_BITS = CDD_WORD_BITS,
   parameter int FRAC_BITS = CDD_FRAC_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [WORD_BITS-1:0] req_sample_time,
   input  logic signed [WORD_BITS-1:0] req_sample_position,
   input  logic                        req_first_of_series,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [WORD_BITS-1:0] rsp_mid_time,
   output logic signed [WORD_BITS-1:0] rsp_mid_position,
   output logic signed [WORD_BITS-1:0] rsp_velocity,
   output logic signed [WORD_BITS-1:0] rsp_acceleration,
   output logic                        rsp_span_error,
   output logic                        rsp_saturated
);

   localparam int W    = WORD_BITS;
   localparam int MW   = W + 1;
   localparam int NUMW = 2 * W + 2 * FRAC_BITS + 3;
   localparam int DIVW = 4 * W + 1;
   localparam int AW   = (NUMW > DIVW) ? NUMW : DIVW;
   localparam int DENW = 3 * W + 1;
   localparam int CW   = $clog2(MW);
   localparam int SHL  = 2 * FRAC_BITS + 1;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DEN1 = 4'd1;
   localparam logic [3:0] S_LDD2 = 4'd2;
   localparam logic [3:0] S_DEN2 = 4'd3;
   localparam logic [3:0] S_LDN1 = 4'd4;
   localparam logic [3:0] S_NUM1 = 4'd5;
   localparam logic [3:0] S_LDN2 = 4'd6;
   localparam logic [3:0] S_NUM2 = 4'd7;
   localparam logic [3:0] S_LDA  = 4'd8;
   localparam logic [3:0] S_DIVA = 4'd9;
   localparam logic [3:0] S_LDV  = 4'd10;
   localparam logic [3:0] S_DIVV = 4'd11;
   localparam logic [3:0] S_DONE = 4'd12;

   localparam logic [1:0] FILL_EMPTY = 2'd0;
   localparam logic [1:0] FILL_ONE   = 2'd1;
   localparam logic [1:0] FILL_TWO   = 2'd2;

   localparam logic [CW-1:0] STEPS_LAST = CW'(W);

   function automatic logic [W:0] mag_of(input logic [W:0] x);
      mag_of = x[W] ? (~x + 1'b1) : x;
   endfunction

   // returns {clipped, two's complement value}
   function automatic logic [W:0] sat_of(input logic [W:0] q, input logic neg);
      logic [W:0] lim;
      logic [W:0] m;
      logic       clip;
      lim    = {2'b00, {(W-1){1'b1}}} + {{W{1'b0}}, neg};
      clip   = q > lim;
      m      = clip ? lim : q;
      sat_of = {clip, neg ? (~m[W-1:0] + 1'b1) : m[W-1:0]};
   endfunction

   logic [3:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    fill_ff, fill_in;
   logic [W-1:0]  older_time_ff, older_time_in;
   logic [W-1:0]  older_pos_ff, older_pos_in;
   logic [W-1:0]  mid_time_ff, mid_time_in;
   logic [W-1:0]  mid_pos_ff, mid_pos_in;
   logic [W-1:0]  hold_time_ff, hold_time_in;
   logic [W-1:0]  hold_pos_ff, hold_pos_in;
   logic [W:0]    dt1_ff, dt1_in;
   logic [W:0]    dt2_ff, dt2_in;
   logic [W:0]    dts_ff, dts_in;
   logic [W:0]    dp1_ff, dp1_in;
   logic [W:0]    dp2_ff, dp2_in;
   logic [W:0]    dps_ff, dps_in;
   logic          err_ff, err_in;
   logic          neg_ff, neg_in;
   logic [W-1:0]  acc_ff, acc_in;
   logic          acc_clip_ff, acc_clip_in;
   logic [DENW-1:0] den_ff, den_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]  rsp_time_ff, rsp_time_in;
   logic [W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [W-1:0]  rsp_vel_ff, rsp_vel_in;
   logic [W-1:0]  rsp_acc_ff, rsp_acc_in;
   logic          rsp_err_ff, rsp_err_in;
   logic          rsp_sat_ff, rsp_sat_in;

   logic          req_xfer;
   logic          restart;
   logic [W:0]    in_dt1, in_dt2, in_dts, in_dp1, in_dp2, in_dps;
   logic          in_err;
   logic [W:0]    vel_sat;
   logic [W:0]    acc_sat;

   cdd_ctl_type   ctl;
   logic [AW-1:0] r_ld, y_ld, r_out;
   logic [MW-1:0] m_ld, m_out;
   logic          r_neg;

   cdd_iter_unit #(
      .AW  (AW),
      .MW  (MW),
      .SHL (SHL)
   ) u_unit (
      .clock (clock),
      .ctl   (ctl),
      .r_ld  (r_ld),
      .y_ld  (y_ld),
      .m_ld  (m_ld),
      .r_out (r_out),
      .m_out (m_out),
      .r_neg (r_neg)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign restart   = req_first_of_series || (fill_ff == FILL_EMPTY);

   assign in_dt1 = {mid_time_ff[W-1], mid_time_ff} - {older_time_ff[W-1], older_time_ff};
   assign in_dt2 = {req_sample_time[W-1], req_sample_time} - {mid_time_ff[W-1], mid_time_ff};
   assign in_dts = {req_sample_time[W-1], req_sample_time}
                 - {older_time_ff[W-1], older_time_ff};
   assign in_dp1 = {mid_pos_ff[W-1], mid_pos_ff} - {older_pos_ff[W-1], older_pos_ff};
   assign in_dp2 = {req_sample_position[W-1], req_sample_position}
                 - {mid_pos_ff[W-1], mid_pos_ff};
   assign in_dps = {req_sample_position[W-1], req_sample_position}
                 - {older_pos_ff[W-1], older_pos_ff};
   assign in_err = in_dt1[W] || (in_dt1 == '0) || in_dt2[W] || (in_dt2 == '0);

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      fill_in       = fill_ff;
      older_time_in = older_time_ff;
      older_pos_in  = older_pos_ff;
      mid_time_in   = mid_time_ff;
      mid_pos_in    = mid_pos_ff;
      hold_time_in  = hold_time_ff;
      hold_pos_in   = hold_pos_ff;
      dt1_in        = dt1_ff;
      dt2_in        = dt2_ff;
      dts_in        = dts_ff;
      dp1_in        = dp1_ff;
      dp2_in        = dp2_ff;
      dps_in        = dps_ff;
      err_in        = err_ff;
      neg_in        = neg_ff;
      acc_in        = acc_ff;
      acc_clip_in   = acc_clip_ff;
      den_in        = den_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_time_in   = rsp_time_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_vel_in    = rsp_vel_ff;
      rsp_acc_in    = rsp_acc_ff;
      rsp_err_in    = rsp_err_ff;
      rsp_sat_in    = rsp_sat_ff;
      ctl.op        = OP_HOLD;
      ctl.sub       = 1'b0;
      r_ld          = '0;
      y_ld          = '0;
      m_ld          = '0;
      vel_sat       = sat_of(m_out, neg_ff);
      acc_sat       = sat_of(m_out, neg_ff);

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               mid_time_in = req_sample_time;
               mid_pos_in  = req_sample_position;
               if (restart) begin
                  fill_in = FILL_ONE;
               end else begin
                  older_time_in = mid_time_ff;
                  older_pos_in  = mid_pos_ff;
                  fill_in       = FILL_TWO;
                  if (fill_ff[1]) begin
                     hold_time_in = mid_time_ff;
                     hold_pos_in  = mid_pos_ff;
                     dt1_in       = in_dt1;
                     dt2_in       = in_dt2;
                     dts_in       = in_dts;
                     dp1_in       = in_dp1;
                     dp2_in       = in_dp2;
                     dps_in       = in_dps;
                     err_in       = in_err;
                     if (in_err) begin
                        state_in = S_DONE;
                     end else begin
                        // start dt1 * dt2
                        state_in = S_DEN1;
                        cnt_in   = STEPS_LAST;
                        ctl.op   = OP_LOAD;
                        y_ld     = {{(AW-W){1'b0}}, in_dt1[W-1:0]};
                        m_ld     = in_dt2;
                     end
                  end
               end
            end
         end
         S_DEN1: begin
            ctl.op = OP_MUL;
            if (cnt_ff == '0) begin
               state_in = S_LDD2;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_LDD2: begin
            ctl.op   = OP_LOAD;
            y_ld     = r_out;
            m_ld     = dts_ff;
            state_in = S_DEN2;
            cnt_in   = STEPS_LAST;
         end
         S_DEN2: begin
            ctl.op = OP_MUL;
            if (cnt_ff == '0) begin
               state_in = S_LDN1;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_LDN1: begin
            den_in   = r_out[DENW-1:0];
            ctl.op   = OP_LOAD;
            y_ld     = {{(AW-W){1'b0}}, dt1_ff[W-1:0]};
            m_ld     = mag_of(dp2_ff);
            state_in = S_NUM1;
            cnt_in   = STEPS_LAST;
         end
         S_NUM1: begin
            ctl.op  = OP_MUL;
            ctl.sub = dp2_ff[W];
            if (cnt_ff == '0) begin
               state_in = S_LDN2;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_LDN2: begin
            // keep the running sum, bring in dt2 * |dp1|
            ctl.op   = OP_LOAD;
            r_ld     = r_out;
            y_ld     = {{(AW-W){1'b0}}, dt2_ff[W-1:0]};
            m_ld     = mag_of(dp1_ff);
            state_in = S_NUM2;
            cnt_in   = STEPS_LAST;
         end
         S_NUM2: begin
            ctl.op  = OP_MUL;
            ctl.sub = ~dp1_ff[W];
            if (cnt_ff == '0) begin
               state_in = S_LDA;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_LDA: begin
            ctl.op   = OP_ABS;
            y_ld     = {{(AW-DENW){1'b0}}, den_ff} << W;
            neg_in   = r_neg;
            state_in = S_DIVA;
            cnt_in   = STEPS_LAST;
         end
         S_DIVA: begin
            ctl.op = OP_DIV;
            if (cnt_ff == '0) begin
               state_in = S_LDV;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_LDV: begin
            acc_clip_in = acc_sat[W];
            acc_in      = acc_sat[W-1:0];
            neg_in      = dps_ff[W];
            ctl.op      = OP_LOAD;
            r_ld        = {{(AW-MW){1'b0}}, mag_of(dps_ff)} << FRAC_BITS;
            y_ld        = {{(AW-MW){1'b0}}, dts_ff} << W;
            state_in    = S_DIVV;
            cnt_in      = STEPS_LAST;
         end
         S_DIVV: begin
            ctl.op = OP_DIV;
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_DONE: begin
            // write only when the output register is free or draining
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_time_in  = hold_time_ff;
               rsp_pos_in   = hold_pos_ff;
               rsp_err_in   = err_ff;
               if (err_ff) begin
                  rsp_vel_in = '0;
                  rsp_acc_in = '0;
                  rsp_sat_in = 1'b0;
               end else begin
                  rsp_vel_in = vel_sat[W-1:0];
                  rsp_acc_in = acc_ff;
                  rsp_sat_in = vel_sat[W] || acc_clip_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         fill_ff       <= FILL_EMPTY;
         older_time_ff <= '0;
         older_pos_ff  <= '0;
         mid_time_ff   <= '0;
         mid_pos_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         fill_ff       <= fill_in;
         older_time_ff <= older_time_in;
         older_pos_ff  <= older_pos_in;
         mid_time_ff   <= mid_time_in;
         mid_pos_ff    <= mid_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_time_ff <= hold_time_in;
      hold_pos_ff  <= hold_pos_in;
      dt1_ff       <= dt1_in;
      dt2_ff       <= dt2_in;
      dts_ff       <= dts_in;
      dp1_ff       <= dp1_in;
      dp2_ff       <= dp2_in;
      dps_ff       <= dps_in;
      err_ff       <= err_in;
      neg_ff       <= neg_in;
      acc_ff       <= acc_in;
      acc_clip_ff  <= acc_clip_in;
      den_ff       <= den_in;
      rsp_time_ff  <= rsp_time_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_vel_ff   <= rsp_vel_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mid_time     = rsp_time_ff;
   assign rsp_mid_position = rsp_pos_ff;
   assign rsp_velocity     = rsp_vel_ff;
   assign rsp_acceleration = rsp_acc_ff;
   assign rsp_span_error   = rsp_err_ff;
   assign rsp_saturated    = rsp_sat_ff;

   `CDD_ASSERT_NEXT(a_full_starts_work, req_xfer && fill_ff[1] && !req_first_of_series, state_ff != S_IDLE, "full window transfer did not start work")
   `CDD_ASSERT_NOW(a_err_zero_rates, rsp_valid && rsp_span_error, rsp_velocity == '0 && rsp_acceleration == '0 && !rsp_saturated, "span error result carries rates")
   `CDD_ASSERT_NEXT(a_divv_to_done, state_ff == S_DIVV && cnt_ff == '0, state_ff == S_DONE, "velocity division did not finish")
   `CDD_ASSERT_NOW(a_fill_code, 1'b1, !(fill_ff[1] && fill_ff[0]), "window fill reached unused code")

endmodule
